[hdl/npsrch_pkg.sv]
// Shared types and widths for the nearest point search block.
package npsrch_pkg;

  localparam int COORD_W = 32;   // coordinate width seen by the distance cells
  localparam int SQ_W    = 64;   // one squared axis difference
  localparam int DIST_W  = 65;   // sum of two squared differences
  localparam int ID_W    = 31;
  localparam int LAT_W   = 31;
  localparam int LON_W   = 32;
  localparam int CNT_W   = 11;   // active_count register width
  localparam int SLOT_W  = 10;
  localparam int CELL_LAT = 3;   // register stages inside one distance cell

  // input item operation codes
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0]  dist_t;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

endpackage

[hdl/npsrch_table.sv]
// Point table: single write port, single registered read port.
module npsrch_table #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  npsrch_pkg::entry_t   wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output npsrch_pkg::entry_t   rdata
);

  npsrch_pkg::entry_t mem [DEPTH];
  npsrch_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/npsrch_cell.sv]
// Distance cell: adds one squared axis difference to the partial sum from its neighbour.
module npsrch_cell (
  input  logic               clk,
  input  npsrch_pkg::coord_t q,
  input  npsrch_pkg::coord_t p,
  input  npsrch_pkg::dist_t  sum_in,
  output npsrch_pkg::dist_t  sum_out
);

  logic [npsrch_pkg::COORD_W:0]   diff;
  logic [npsrch_pkg::COORD_W-1:0] mag;
  logic [npsrch_pkg::COORD_W-1:0] d_r;
  logic [npsrch_pkg::SQ_W-1:0]    sq_r;
  npsrch_pkg::dist_t              s1_r;
  npsrch_pkg::dist_t              s2_r;
  npsrch_pkg::dist_t              out_r;

  always_comb begin
    diff = {q[npsrch_pkg::COORD_W-1], q} - {p[npsrch_pkg::COORD_W-1], p};
    mag  = diff[npsrch_pkg::COORD_W] ? npsrch_pkg::COORD_W'(~diff + 1'b1)
                                     : diff[npsrch_pkg::COORD_W-1:0];
  end

  // magnitude, square, accumulate: one register each
  always_ff @(posedge clk) begin
    d_r   <= mag;
    s1_r  <= sum_in;
    sq_r  <= npsrch_pkg::SQ_W'(d_r) * npsrch_pkg::SQ_W'(d_r);
    s2_r  <= s1_r;
    out_r <= s2_r + npsrch_pkg::DIST_W'(sq_r);
  end

  assign sum_out = out_r;

endmodule

[hdl/nearest_point_search.sv]
// Nearest point search: point table scanned through a chain of distance cells.
//
// Input channel (in_*): func 0 stores point_id/latitude/longitude in slot,
// func 1 searches for the stored point closest to latitude/longitude.
// A transfer takes place when in_valid is high and in_stall is low.
// Result channel (out_*): one transfer per search, none per write; out_found
// is low and out_nearest_id zero when no slot is active. Ties go to the
// lowest slot.
// cfg_we/cfg_wdata set active_count, the number of slots scanned from slot
// zero (saturated at TABLE_DEPTH). Write it only while the block is idle.
// A search reads one slot per cycle from the table's single read port, then
// passes through the two-cell distance chain and the running-minimum register.
// in_stall is high during a search.
// The result waits in an output register; a finished search holds there
// until out_stall drops, and a new item may be taken while it waits.
// Reset clears active_count and the control state; table contents are
// undefined until written.
module nearest_point_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [npsrch_pkg::CNT_W-1:0]           cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_func,
  input  logic [npsrch_pkg::SLOT_W-1:0]          in_slot,
  input  logic [npsrch_pkg::ID_W-1:0]            in_point_id,
  input  logic signed [npsrch_pkg::LAT_W-1:0]    in_latitude,
  input  logic signed [npsrch_pkg::LON_W-1:0]    in_longitude,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_found,
  output logic [npsrch_pkg::ID_W-1:0]            out_nearest_id
);

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int CW     = $clog2(TABLE_DEPTH + 1);
  localparam int LAT    = npsrch_pkg::CELL_LAT;
  localparam int TAGS   = 2 * LAT + 1;

  npsrch_pkg::state_t            state_r, state_nxt;
  logic [npsrch_pkg::CNT_W-1:0]  active_r;
  logic [CW-1:0]                 count_sat;
  logic [CW-1:0]                 count_r;
  logic [AW-1:0]                 addr_r;
  logic                          issue;
  logic                          issue_last;
  npsrch_pkg::coord_t            q_lat_r, q_lon_r;
  npsrch_pkg::tag_t              tag_r [TAGS];
  logic [npsrch_pkg::ID_W-1:0]   id_dly_r [2*LAT];
  npsrch_pkg::coord_t            lon_dly_r [LAT];
  npsrch_pkg::entry_t            wr_entry, rd_entry;
  npsrch_pkg::coord_t            p_lat;
  npsrch_pkg::dist_t             sum0, sum1;
  npsrch_pkg::dist_t             best_r;
  logic [npsrch_pkg::ID_W-1:0]   best_id_r;
  logic                          found_r;
  logic                          out_valid_r, out_found_r;
  logic [npsrch_pkg::ID_W-1:0]   out_id_r;
  logic                          in_xfer, wr_xfer, srch_xfer;
  logic                          wr_ok;
  logic                          end_tag;
  logic                          better;
  logic                          load_out;

  assign in_stall  = (state_r != npsrch_pkg::S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign wr_xfer   = in_xfer && (in_func == npsrch_pkg::FUNC_WRITE);
  assign srch_xfer = in_xfer && (in_func == npsrch_pkg::FUNC_SEARCH);
  assign wr_ok     = (32'(in_slot) < TABLE_DEPTH);

  assign count_sat = (32'(active_r) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(active_r);

  assign issue      = (state_r == npsrch_pkg::S_SCAN);
  assign issue_last = ((CW'(addr_r) + CW'(1)) == count_r);
  assign end_tag    = tag_r[TAGS-1].valid && tag_r[TAGS-1].last;
  assign load_out   = (state_r == npsrch_pkg::S_FINISH) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      npsrch_pkg::S_IDLE: begin
        if (srch_xfer) begin
          state_nxt = (count_sat == '0) ? npsrch_pkg::S_FINISH : npsrch_pkg::S_SCAN;
        end
      end
      npsrch_pkg::S_SCAN: begin
        if (issue_last) begin
          state_nxt = npsrch_pkg::S_DRAIN;
        end
      end
      npsrch_pkg::S_DRAIN: begin
        if (end_tag) begin
          state_nxt = npsrch_pkg::S_FINISH;
        end
      end
      npsrch_pkg::S_FINISH: begin
        if (load_out) begin
          state_nxt = npsrch_pkg::S_IDLE;
        end
      end
      default: state_nxt = npsrch_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= npsrch_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // scan address and query capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r  <= '0;
      count_r <= '0;
    end else if (srch_xfer) begin
      addr_r  <= '0;
      count_r <= count_sat;
    end else if (issue) begin
      addr_r  <= addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (srch_xfer) begin
      q_lat_r <= {in_latitude[npsrch_pkg::LAT_W-1], in_latitude};
      q_lon_r <= in_longitude;
    end
  end

  assign wr_entry = '{id: in_point_id, lat: in_latitude, lon: in_longitude};

  npsrch_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (wr_xfer && wr_ok),
    .waddr (AW'(in_slot)),
    .wdata (wr_entry),
    .re    (issue),
    .raddr (addr_r),
    .rdata (rd_entry)
  );

  // tag line follows each read through both cells
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAGS; i++) begin
        tag_r[i] <= '0;
      end
    end else begin
      tag_r[0] <= '{valid: issue, last: issue_last};
      for (int i = 1; i < TAGS; i++) begin
        tag_r[i] <= tag_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    id_dly_r[0]  <= rd_entry.id;
    lon_dly_r[0] <= rd_entry.lon;
    for (int i = 1; i < 2*LAT; i++) begin
      id_dly_r[i] <= id_dly_r[i-1];
    end
    for (int i = 1; i < LAT; i++) begin
      lon_dly_r[i] <= lon_dly_r[i-1];
    end
  end

  assign p_lat = {rd_entry.lat[npsrch_pkg::LAT_W-1], rd_entry.lat};

  npsrch_cell u_cell_lat (
    .clk     (clk),
    .q       (q_lat_r),
    .p       (p_lat),
    .sum_in  ('0),
    .sum_out (sum0)
  );

  npsrch_cell u_cell_lon (
    .clk     (clk),
    .q       (q_lon_r),
    .p       (lon_dly_r[LAT-1]),
    .sum_in  (sum0),
    .sum_out (sum1)
  );

  // running minimum; strict compare keeps the lowest slot on a tie
  assign better = !found_r || (sum1 < best_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r   <= 1'b0;
      best_id_r <= '0;
    end else if (srch_xfer) begin
      found_r   <= 1'b0;
      best_id_r <= '0;
    end else if (tag_r[TAGS-1].valid && better) begin
      found_r   <= 1'b1;
      best_id_r <= id_dly_r[2*LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (tag_r[TAGS-1].valid && better) begin
      best_r <= sum1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found_r <= found_r;
      out_id_r    <= best_id_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_nearest_id = out_id_r;

  a_tag_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tag_r[TAGS-1].valid |-> (state_r == npsrch_pkg::S_SCAN || state_r == npsrch_pkg::S_DRAIN))
    else $error("candidate left the cell chain outside a search");

  a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == npsrch_pkg::S_FINISH) |-> !tag_r[TAGS-1].valid && !tag_r[0].valid)
    else $error("result taken while candidates still in flight");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_nearest_id == '0))
    else $error("empty search returned a non-zero identifier");

  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == npsrch_pkg::S_FINISH && !out_valid_r) |=> out_valid_r)
    else $error("finished search did not reach the output register");

endmodule

[test/nearest_point_search_test.sv]
// Self-checking testbench for the nearest point search block.
module nearest_point_search_test;

  localparam int DEPTH = 1024;

  localparam logic signed [npsrch_pkg::LAT_W-1:0] LAT_MIN =
    {1'b1, {(npsrch_pkg::LAT_W-1){1'b0}}};
  localparam logic signed [npsrch_pkg::LAT_W-1:0] LAT_MAX =
    {1'b0, {(npsrch_pkg::LAT_W-1){1'b1}}};
  localparam logic signed [npsrch_pkg::LON_W-1:0] LON_MIN =
    {1'b1, {(npsrch_pkg::LON_W-1){1'b0}}};
  localparam logic signed [npsrch_pkg::LON_W-1:0] LON_MAX =
    {1'b0, {(npsrch_pkg::LON_W-1){1'b1}}};

  typedef struct {
    logic                       found;
    logic [npsrch_pkg::ID_W-1:0] id;
  } nearest_result_t;

  logic                                  clk;
  logic                                  rst_n;
  logic                                  cfg_we;
  logic [npsrch_pkg::CNT_W-1:0]          cfg_wdata;
  logic                                  in_valid;
  logic                                  in_stall;
  logic                                  in_func;
  logic [npsrch_pkg::SLOT_W-1:0]         in_slot;
  logic [npsrch_pkg::ID_W-1:0]           in_point_id;
  logic signed [npsrch_pkg::LAT_W-1:0]   in_latitude;
  logic signed [npsrch_pkg::LON_W-1:0]   in_longitude;
  logic                                  out_valid;
  logic                                  out_stall;
  logic                                  out_found;
  logic [npsrch_pkg::ID_W-1:0]           out_nearest_id;

  // Mirror of the block's table and register
  npsrch_pkg::entry_t           point_table [DEPTH];
  logic [npsrch_pkg::CNT_W-1:0] active_count_q = '0;
  nearest_result_t              pending_nearest [$];

  int  mismatch_count = 0;
  int  random_items = 0;
  int  output_hold_cycles = 0;
  bit  sender_gaps = 1'b0;
  bit  receiver_gaps = 1'b0;

  nearest_point_search #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_slot        (in_slot),
    .in_point_id    (in_point_id),
    .in_latitude    (in_latitude),
    .in_longitude   (in_longitude),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .out_nearest_id (out_nearest_id)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Time limit on the whole run; report failure if it is reached.
  initial begin
    #100_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Exact squared distance, carry bit included
  function automatic npsrch_pkg::dist_t squared_distance(
      input logic signed [npsrch_pkg::LAT_W-1:0] a_lat,
      input logic signed [npsrch_pkg::LON_W-1:0] a_lon,
      input logic signed [npsrch_pkg::LAT_W-1:0] b_lat,
      input logic signed [npsrch_pkg::LON_W-1:0] b_lon);
    logic [32:0]        d_lat;
    logic [32:0]        d_lon;
    npsrch_pkg::dist_t  sq_lat;
    npsrch_pkg::dist_t  sq_lon;
    d_lat = {{2{a_lat[npsrch_pkg::LAT_W-1]}}, a_lat} - {{2{b_lat[npsrch_pkg::LAT_W-1]}}, b_lat};
    d_lon = {a_lon[npsrch_pkg::LON_W-1], a_lon} - {b_lon[npsrch_pkg::LON_W-1], b_lon};
    if (d_lat[32]) d_lat = -d_lat;
    if (d_lon[32]) d_lon = -d_lon;
    sq_lat = npsrch_pkg::DIST_W'(d_lat);
    sq_lat = sq_lat * sq_lat;
    sq_lon = npsrch_pkg::DIST_W'(d_lon);
    sq_lon = sq_lon * sq_lon;
    return sq_lat + sq_lon;
  endfunction

  function automatic int scan_limit();
    return (int'(active_count_q) > DEPTH) ? DEPTH : int'(active_count_q);
  endfunction

  function automatic nearest_result_t predict_nearest(
      input logic signed [npsrch_pkg::LAT_W-1:0] q_lat,
      input logic signed [npsrch_pkg::LON_W-1:0] q_lon);
    nearest_result_t    best;
    npsrch_pkg::dist_t  best_dist;
    npsrch_pkg::dist_t  d;
    best.found = 1'b0;
    best.id    = '0;
    best_dist  = '0;
    for (int i = 0; i < scan_limit(); i++) begin
      d = squared_distance(q_lat, q_lon, point_table[i].lat, point_table[i].lon);
      // strict compare keeps the lowest slot on a tie
      if (!best.found || d < best_dist) begin
        best.found = 1'b1;
        best.id    = point_table[i].id;
        best_dist  = d;
      end
    end
    return best;
  endfunction

  function automatic logic signed [npsrch_pkg::LAT_W-1:0] pick_latitude();
    logic signed [npsrch_pkg::LAT_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = npsrch_pkg::LAT_W'($urandom);
      1: v = npsrch_pkg::LAT_W'(int'($urandom_range(0, 8)) - 4);
      2: v = npsrch_pkg::LAT_W'(int'($urandom_range(0, 1_800_000_000)) - 900_000_000);
      default: v = $urandom_range(0, 1) ? LAT_MAX : LAT_MIN;
    endcase
    return v;
  endfunction

  function automatic logic signed [npsrch_pkg::LON_W-1:0] pick_longitude();
    logic signed [npsrch_pkg::LON_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = int'($urandom_range(0, 8)) - 4;
      2: v = $urandom_range(0, 32'd3_600_000_000) - 32'd1_800_000_000;
      default: v = $urandom_range(0, 1) ? LON_MAX : LON_MIN;
    endcase
    return v;
  endfunction

  task automatic report_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Append one expected result behind those already waiting
  task automatic queue_expected(input nearest_result_t r);
    pending_nearest = {pending_nearest, r};
  endtask

  // Offer one item and hold it until the transfer; valid is left high
  task automatic send_item(input logic func, input logic [npsrch_pkg::SLOT_W-1:0] slot,
                           input logic [npsrch_pkg::ID_W-1:0] pid,
                           input logic signed [npsrch_pkg::LAT_W-1:0] lat,
                           input logic signed [npsrch_pkg::LON_W-1:0] lon);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= func;
    in_slot      <= slot;
    in_point_id  <= pid;
    in_latitude  <= lat;
    in_longitude <= lon;
    do @(posedge clk); while (in_stall);
    if (func == npsrch_pkg::FUNC_WRITE) begin
      point_table[slot].id  = pid;
      point_table[slot].lat = lat;
      point_table[slot].lon = lon;
    end else begin
      queue_expected(predict_nearest(lat, lon));
    end
  endtask

  task automatic write_point(input logic [npsrch_pkg::SLOT_W-1:0] slot,
                             input logic [npsrch_pkg::ID_W-1:0] pid,
                             input logic signed [npsrch_pkg::LAT_W-1:0] lat,
                             input logic signed [npsrch_pkg::LON_W-1:0] lon);
    send_item(npsrch_pkg::FUNC_WRITE, slot, pid, lat, lon);
  endtask

  // slot and id are ignored by a search, so feed them noise
  task automatic search_point(input logic signed [npsrch_pkg::LAT_W-1:0] lat,
                              input logic signed [npsrch_pkg::LON_W-1:0] lon);
    send_item(npsrch_pkg::FUNC_SEARCH, npsrch_pkg::SLOT_W'($urandom),
              npsrch_pkg::ID_W'($urandom), lat, lon);
  endtask

  // Drop valid and wait until every search has answered and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_nearest.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_active_count(input logic [npsrch_pkg::CNT_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    active_count_q = value;
    cfg_we <= 1'b0;
  endtask

  task automatic test_empty_table();
    search_point(LAT_MAX, LON_MIN);
    write_point(10'd0, 31'h2AAA_AAAA, 31'sd5, -32'sd7);
    search_point(31'sd5, -32'sd7);
  endtask

  task automatic test_extremes_and_ties();
    write_point(10'd0, 31'h0000_0000, LAT_MIN, LON_MIN);
    write_point(10'd1, 31'h7FFF_FFFF, LAT_MAX, LON_MIN);
    write_point(10'd2, 31'h2AAA_AAAA, '0, '0);
    write_point(10'd3, 31'h5555_5555, '0, '0);
    write_point(10'd4, 31'h0123_4567, LAT_MAX, LON_MAX);
    write_point(10'd5, 31'd1, -31'sd900_000_000, 32'sd1_800_000_000);
    // slot 0 overflows into the carry bit, slot 1 stays just below it
    set_active_count(11'd2);
    search_point(LAT_MAX, LON_MAX);
    set_active_count(11'd6);
    search_point('0, '0);
    search_point(LAT_MAX, LON_MAX);
    search_point(LAT_MIN, LON_MIN);
    search_point(-31'sd900_000_000, 32'sd1_800_000_000);
    search_point(31'sd3, -32'sd2);
    // single slot holding id zero must still report found
    set_active_count(11'd1);
    search_point(LAT_MAX, LON_MAX);
  endtask

  task automatic test_full_table();
    set_active_count(11'd0);
    for (int s = 0; s < DEPTH; s++) begin
      write_point(npsrch_pkg::SLOT_W'(s), npsrch_pkg::ID_W'($urandom), pick_latitude(),
                  pick_longitude());
    end
    set_active_count(npsrch_pkg::CNT_W'(DEPTH));
    repeat (3) search_point(pick_latitude(), pick_longitude());
    // counts above the table saturate
    set_active_count('1);
    repeat (3) search_point(pick_latitude(), pick_longitude());
    set_active_count(npsrch_pkg::CNT_W'(DEPTH + 1));
    repeat (2) search_point(pick_latitude(), pick_longitude());
  endtask

  task automatic test_output_hold();
    set_active_count(11'd16);
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    output_hold_cycles = 400;
    for (int k = 0; k < 8; k++) begin
      if (k % 3 == 1) write_point(npsrch_pkg::SLOT_W'($urandom_range(0, 15)),
                                  npsrch_pkg::ID_W'($urandom), pick_latitude(),
                                  pick_longitude());
      else search_point(pick_latitude(), pick_longitude());
    end
    settle();
  endtask

  task automatic test_random_traffic();
    int unsigned                   n;
    int                            lim;
    int unsigned                   src;
    logic [npsrch_pkg::SLOT_W-1:0] slot;
    while (random_items < 580) begin
      case ($urandom_range(0, 19))
        0, 1:          n = 0;
        2, 3, 4, 5:    n = $urandom_range(1, 8);
        6:             n = $urandom_range(DEPTH, 2047);
        7, 8:          n = $urandom_range(65, 300);
        default:       n = $urandom_range(1, 64);
      endcase
      set_active_count(npsrch_pkg::CNT_W'(n));
      lim = scan_limit();
      // the tail of the run goes without idling on either side
      sender_gaps   = (random_items < 480) && ($urandom_range(0, 3) != 0);
      receiver_gaps = (random_items < 480) && ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(30, 50)) begin
        if ($urandom_range(0, 99) < 35) begin
          slot = (lim > 0 && $urandom_range(0, 1))
                 ? npsrch_pkg::SLOT_W'($urandom_range(0, lim - 1))
                 : npsrch_pkg::SLOT_W'($urandom_range(0, DEPTH - 1));
          if ($urandom_range(0, 3) == 0) begin
            // copy another point so that ties turn up
            src = $urandom_range(0, DEPTH - 1);
            write_point(slot, npsrch_pkg::ID_W'($urandom), point_table[src].lat,
                        point_table[src].lon);
          end else begin
            write_point(slot, npsrch_pkg::ID_W'($urandom), pick_latitude(),
                        pick_longitude());
          end
        end else if (lim > 0 && $urandom_range(0, 3) == 0) begin
          src = $urandom_range(0, lim - 1);
          search_point(point_table[src].lat, point_table[src].lon);
        end else begin
          search_point(pick_latitude(), pick_longitude());
        end
        random_items++;
      end
    end
  endtask

  // Receiver: random stall bursts, or one long hold when asked
  initial begin
    forever begin
      if (output_hold_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (output_hold_cycles) @(posedge clk);
        output_hold_cycles = 0;
      end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    nearest_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_nearest.size() == 0) begin
        report_error($sformatf("result with nothing pending: found=%0b id=0x%08h",
                               out_found, out_nearest_id));
      end else begin
        want = pending_nearest.pop_front();
        if (out_found !== want.found)
          report_error($sformatf("found: expected %0b, got %0b", want.found, out_found));
        if (out_nearest_id !== want.id)
          report_error($sformatf("nearest_id: expected 0x%08h, got 0x%08h",
                                 want.id, out_nearest_id));
      end
    end
  end

  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    in_func      <= npsrch_pkg::FUNC_WRITE;
    in_slot      <= '0;
    in_point_id  <= '0;
    in_latitude  <= '0;
    in_longitude <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    test_empty_table();
    test_extremes_and_ties();
    test_full_table();
    test_output_hold();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_nearest.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    if (mismatch_count == 0 && pending_nearest.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/npsrch_pkg.sv
hdl/npsrch_table.sv
hdl/npsrch_cell.sv
hdl/nearest_point_search.sv
test/nearest_point_search_test.sv
